>>> rtl/core/itp_pkg.sv
// shared types, codes and character helpers for the infix to postfix converter
package itp_pkg;

  localparam logic [7:0] CHAR_LOW_A  = 8'd97;
  localparam logic [7:0] CHAR_LOW_Z  = 8'd122;
  localparam logic [7:0] CHAR_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_PLUS   = 8'h2b;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;

  typedef logic [2:0] op_code_t;
  localparam op_code_t CODE_NONE = 3'd0;
  localparam op_code_t CODE_OPEN = 3'd1;
  localparam op_code_t CODE_ADD  = 3'd2;
  localparam op_code_t CODE_SUB  = 3'd3;
  localparam op_code_t CODE_MUL  = 3'd4;
  localparam op_code_t CODE_DIV  = 3'd5;

  typedef logic [2:0] err_code_t;
  localparam err_code_t ERR_NONE     = 3'd0;
  localparam err_code_t ERR_OVERFLOW = 3'd1;
  localparam err_code_t ERR_CLOSE    = 3'd2;
  localparam err_code_t ERR_ILLEGAL  = 3'd3;
  localparam err_code_t ERR_OPEN     = 3'd4;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_BAD
  } sym_class_t;

  // result request from the sequencer to the output buffer
  typedef struct packed {
    logic      push;
    logic      close;
    logic [7:0] sym;
    err_code_t err;
  } emit_req_t;

  // output buffer status back to the sequencer
  typedef struct packed {
    logic hold_valid;
    logic blocked;
  } ob_status_t;

  function automatic sym_class_t classify(input logic [7:0] c);
    sym_class_t cls;
    cls = CLS_BAD;
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) cls = CLS_LETTER;
    else if (c == CHAR_OPEN) cls = CLS_OPEN;
    else if (c == CHAR_CLOSE) cls = CLS_CLOSE;
    else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH)
      cls = CLS_OPER;
    return cls;
  endfunction

  function automatic op_code_t oper_code(input logic [7:0] c);
    op_code_t code;
    code = CODE_NONE;
    if (c == CHAR_PLUS) code = CODE_ADD;
    else if (c == CHAR_MINUS) code = CODE_SUB;
    else if (c == CHAR_STAR) code = CODE_MUL;
    else if (c == CHAR_SLASH) code = CODE_DIV;
    return code;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] ch;
    unique case (code)
      CODE_OPEN: ch = CHAR_OPEN;
      CODE_ADD:  ch = CHAR_PLUS;
      CODE_SUB:  ch = CHAR_MINUS;
      CODE_MUL:  ch = CHAR_STAR;
      CODE_DIV:  ch = CHAR_SLASH;
      default:   ch = 8'd0;
    endcase
    return ch;
  endfunction

  // 1 for * and /, the higher of the two precedence levels
  function automatic logic high_rank(input op_code_t code);
    return (code >= CODE_MUL);
  endfunction

endpackage

>>> rtl/core/itp_stack_ram.sv
// operator stack storage: one write port, one registered read port
module itp_stack_ram import itp_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  op_code_t      wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output op_code_t      rd_data
);

  op_code_t mem [DEPTH];
  op_code_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/itp_out_buf.sv
// result hold slot and output register; marks the final result of each item
module itp_out_buf import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  emit_req_t  req,
  output ob_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output err_code_t  out_error_code,
  output logic       out_last_of_run
);

  logic       out_valid_r;
  logic [7:0] out_sym_r;
  err_code_t  out_err_r;
  logic       out_last_r;
  logic       hold_valid_r;
  logic [7:0] hold_sym_r;
  err_code_t  hold_err_r;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign status.hold_valid = hold_valid_r;
  assign status.blocked    = hold_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (req.push) begin
        // a newer result exists, so the held one is not the last
        if (hold_valid_r) begin
          out_valid_r <= 1'b1;
          out_sym_r   <= hold_sym_r;
          out_err_r   <= hold_err_r;
          out_last_r  <= 1'b0;
        end
        hold_valid_r <= 1'b1;
        hold_sym_r   <= req.sym;
        hold_err_r   <= req.err;
      end else if (req.close && hold_valid_r) begin
        out_valid_r  <= 1'b1;
        out_sym_r    <= hold_sym_r;
        out_err_r    <= hold_err_r;
        out_last_r   <= 1'b1;
        hold_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_sym_r;
  assign out_error_code  = out_err_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> rtl/core/itp_ctrl.sv
// sequencer: classifies a symbol and walks the operator stack one entry per step
module itp_ctrl import itp_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int AW  = 4,
  parameter int SPW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_symbol,
  input  logic          in_end_of_expression,
  input  ob_status_t    status,
  output emit_req_t     req,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output op_code_t      wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  op_code_t      rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE_RD,
    ST_CLOSE_EV,
    ST_OP_RD,
    ST_OP_EV,
    ST_FL_RD,
    ST_FL_EV,
    ST_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic       end_r, end_nxt;
  op_code_t   code_r, code_nxt;
  logic       full;
  logic       empty;
  logic [SPW-1:0] sp_dec;
  state_t     after_item;
  sym_class_t cls;

  assign full   = (sp_r >= SPW'(STACK_DEPTH));
  assign empty  = (sp_r == '0);
  assign sp_dec = sp_r - SPW'(1);
  assign cls    = classify(in_symbol);
  assign in_ready = (state_r == ST_IDLE);
  assign after_item = end_r ? ST_FL_RD : ST_FINISH;

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    end_nxt   = end_r;
    code_nxt  = code_r;
    req       = '0;
    wr_en     = 1'b0;
    wr_addr   = sp_r[AW-1:0];
    wr_data   = code_r;
    rd_en     = 1'b0;
    rd_addr   = sp_dec[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          end_nxt   = in_end_of_expression;
          code_nxt  = oper_code(in_symbol);
          state_nxt = in_end_of_expression ? ST_FL_RD : ST_FINISH;
          unique case (cls)
            CLS_LETTER: begin
              req.push = 1'b1;
              req.sym  = in_symbol;
              req.err  = ERR_NONE;
            end
            CLS_OPEN: begin
              if (full) begin
                req.push = 1'b1;
                req.err  = ERR_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                wr_data = CODE_OPEN;
                sp_nxt  = sp_r + SPW'(1);
              end
            end
            CLS_CLOSE: state_nxt = ST_CLOSE_RD;
            CLS_OPER:  state_nxt = ST_OP_RD;
            default: begin
              req.push = 1'b1;
              req.err  = ERR_ILLEGAL;
            end
          endcase
        end
      end
      ST_CLOSE_RD: begin
        if (!status.blocked) begin
          if (empty) begin
            req.push  = 1'b1;
            req.err   = ERR_CLOSE;
            state_nxt = after_item;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_CLOSE_EV;
          end
        end
      end
      ST_CLOSE_EV: begin
        if (!status.blocked) begin
          sp_nxt = sp_dec;
          if (rd_data == CODE_OPEN) begin
            state_nxt = after_item;
          end else begin
            req.push  = 1'b1;
            req.sym   = code_char(rd_data);
            state_nxt = ST_CLOSE_RD;
          end
        end
      end
      ST_OP_RD: begin
        if (!status.blocked) begin
          if (empty) begin
            wr_en     = 1'b1;
            sp_nxt    = sp_r + SPW'(1);
            state_nxt = after_item;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_OP_EV;
          end
        end
      end
      ST_OP_EV: begin
        if (!status.blocked) begin
          if (rd_data == CODE_OPEN || (high_rank(code_r) && !high_rank(rd_data))) begin
            state_nxt = after_item;
            if (full) begin
              req.push = 1'b1;
              req.err  = ERR_OVERFLOW;
            end else begin
              wr_en  = 1'b1;
              sp_nxt = sp_r + SPW'(1);
            end
          end else begin
            sp_nxt    = sp_dec;
            req.push  = 1'b1;
            req.sym   = code_char(rd_data);
            state_nxt = ST_OP_RD;
          end
        end
      end
      ST_FL_RD: begin
        if (!status.blocked) begin
          if (empty) begin
            state_nxt = ST_FINISH;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_FL_EV;
          end
        end
      end
      ST_FL_EV: begin
        if (!status.blocked) begin
          sp_nxt   = sp_dec;
          req.push = 1'b1;
          if (rd_data == CODE_OPEN) begin
            req.err = ERR_OPEN;
          end else begin
            req.sym = code_char(rd_data);
          end
          state_nxt = ST_FL_RD;
        end
      end
      ST_FINISH: begin
        if (!status.blocked) begin
          req.close = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
    end
    end_r  <= end_nxt;
    code_r <= code_nxt;
  end

endmodule

>>> rtl/core/infix_to_postfix_converter_top.sv
// top level of the infix to postfix converter: sequencer, stack memory, output buffer
//
//  channel | direction | signals                                        | handshake
//  --------+-----------+------------------------------------------------+----------
//  in      | input     | in_symbol[7:0], in_end_of_expression           | valid/ready
//  out     | output    | out_symbol[7:0], out_error_code[2:0], out_last_of_run | valid/ready
//
// steps: a letter, illegal symbol or '(' is accepted, then handed off; each stack entry that
//   ')', an operator or the flush examines is a memory read, then an action on the data; a
//   walk that reaches the empty stack ends with one more check, the end flag adds the flush empty check
// reset: synchronous active low, clears sequencer state, stack pointer and output valids
// stalls: a result waits in a one-entry hold slot until the next one or the item end sets
//   last_of_run; the sequencer pauses while that slot is full and the output is not taken
module infix_to_postfix_converter_top import itp_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_end_of_expression,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic [2:0] out_error_code,
  output logic       out_last_of_run
);

  // stack pointer runs 0..STACK_DEPTH, the memory address 0..STACK_DEPTH-1
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  emit_req_t     req;
  ob_status_t    status;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  op_code_t      mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  op_code_t      mem_rd_data;

  // a push is written into the memory before any read of that entry is issued, so the
  // memory needs no forwarding path
  itp_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW),
    .SPW         (SPW)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_symbol            (in_symbol),
    .in_end_of_expression (in_end_of_expression),
    .status               (status),
    .req                  (req),
    .wr_en                (mem_wr_en),
    .wr_addr              (mem_wr_addr),
    .wr_data              (mem_wr_data),
    .rd_en                (mem_rd_en),
    .rd_addr              (mem_rd_addr),
    .rd_data              (mem_rd_data)
  );

  // operator stack, one code per entry
  itp_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // hold slot plus output register, one transaction per result
  itp_out_buf u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  // a new item never starts while a result of the previous one is still held
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !status.hold_valid)
    else $error("item accepted with a result still held");

  // the sequencer never reads and writes the stack in the same cycle
  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("stack read and write in one cycle");

  // the sequencer issues no result while the buffer is blocked
  a_no_push_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    status.blocked |-> !(req.push || req.close))
    else $error("result issued while the output buffer is blocked");

  // error results carry no symbol
  a_err_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> (out_symbol == 8'd0))
    else $error("error result with a nonzero symbol");
`endif

endmodule

>>> bench/infix_to_postfix_converter_top_tb.sv
// self-checking testbench for the infix to postfix converter top level
module infix_to_postfix_converter_top_tb;
  import itp_pkg::*;

  localparam int STACK_DEPTH = 16;
  // random stimulus starts no new item once this many characters have been accepted
  localparam int RANDOM_ITEMS = 290;
  // cycles without any transaction on either channel before the run is declared hung
  localparam int IDLE_LIMIT = 3000;
  // quiet time after the last expected result, covers a full flush of the stack
  localparam int TAIL_CYCLES = 4 * (STACK_DEPTH + 2);

  // one postfix result as seen on the out channel
  typedef struct packed {
    logic [7:0] sym;
    err_code_t  err;
    logic       last;
  } postfix_t;

  // one row of the directed table; typed rows carry their single result inline
  typedef struct packed {
    logic [7:0] sym;
    logic       eoe;
    int         reps;
    logic       typed;
    logic [7:0] t_sym;
    err_code_t  t_err;
  } drive_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_THIRDS
  } ready_mode_t;

  localparam int DIRECTED_ROWS = 23;
  localparam drive_row_t DIRECTED [DIRECTED_ROWS] = '{
    // single characters right after reset, each gives exactly one result
    '{CHAR_LOW_A, 1'b0, 1, 1'b1, CHAR_LOW_A, ERR_NONE},
    '{CHAR_LOW_Z, 1'b0, 1, 1'b1, CHAR_LOW_Z, ERR_NONE},
    '{8'h00,      1'b0, 1, 1'b1, 8'h00,      ERR_ILLEGAL},
    '{8'hff,      1'b1, 1, 1'b1, 8'h00,      ERR_ILLEGAL},
    '{"A",        1'b0, 1, 1'b1, 8'h00,      ERR_ILLEGAL},
    '{CHAR_CLOSE, 1'b0, 1, 1'b1, 8'h00,      ERR_CLOSE},
    // (a-b)/c+d with the end flag on the last operand
    '{CHAR_OPEN,  1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{"a",        1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_MINUS, 1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{"b",        1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_CLOSE, 1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_SLASH, 1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{"c",        1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_PLUS,  1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{"d",        1'b1, 1, 1'b0, 8'h00, ERR_NONE},
    // fill the stack with opens, then push into a full stack twice
    '{CHAR_OPEN,  1'b0, STACK_DEPTH, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_OPEN,  1'b0, 1, 1'b1, 8'h00, ERR_OVERFLOW},
    '{CHAR_STAR,  1'b0, 1, 1'b1, 8'h00, ERR_OVERFLOW},
    // close consumes one open silently, the flush reports every open left behind
    '{CHAR_CLOSE, 1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{"a",        1'b1, 1, 1'b0, 8'h00, ERR_NONE},
    // close with operators but no open below them
    '{"x",        1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_PLUS,  1'b0, 1, 1'b0, 8'h00, ERR_NONE},
    '{CHAR_CLOSE, 1'b1, 1, 1'b0, 8'h00, ERR_NONE}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_symbol = 8'h00;
  logic       in_end_of_expression = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_symbol;
  logic [2:0] out_error_code;
  logic       out_last_of_run;

  // predictor state: operator stack and its fill level
  op_code_t op_stack [STACK_DEPTH];
  int       op_depth = 0;

  // results of the character just accepted, and the queue of results still owed
  postfix_t step_results [$];
  postfix_t pending_postfix [$];
  postfix_t want;

  int fail_count = 0;
  int chars_sent = 0;
  int idle_cycles = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_len = 0;

  // receiver stall pattern
  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;
  int unsigned ready_tick = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  infix_to_postfix_converter_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_symbol           (in_symbol),
    .in_end_of_expression(in_end_of_expression),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_symbol          (out_symbol),
    .out_error_code      (out_error_code),
    .out_last_of_run     (out_last_of_run)
  );

  // postfix character for an operator code on the stack
  function automatic logic [7:0] op_symbol(input op_code_t code);
    logic [7:0] ch;
    case (code)
      CODE_ADD: ch = CHAR_PLUS;
      CODE_SUB: ch = CHAR_MINUS;
      CODE_MUL: ch = CHAR_STAR;
      CODE_DIV: ch = CHAR_SLASH;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  // push onto the operator stack, a full stack drops the code and flags overflow
  function automatic void stack_push(input op_code_t code);
    if (op_depth >= STACK_DEPTH) begin
      step_results.push_back('{8'h00, ERR_OVERFLOW, 1'b0});
    end else begin
      op_stack[op_depth] = code;
      op_depth++;
    end
  endfunction

  // shunting-yard step for one character, results land in step_results
  function automatic void shunt_step(input logic [7:0] c, input logic eoe);
    op_code_t code;
    op_code_t top;
    logic     matched;
    step_results = {};
    matched = 1'b0;
    code = CODE_NONE;
    if (c == CHAR_PLUS) code = CODE_ADD;
    else if (c == CHAR_MINUS) code = CODE_SUB;
    else if (c == CHAR_STAR) code = CODE_MUL;
    else if (c == CHAR_SLASH) code = CODE_DIV;

    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      step_results.push_back('{c, ERR_NONE, 1'b0});
    end else if (c == CHAR_OPEN) begin
      stack_push(CODE_OPEN);
    end else if (c == CHAR_CLOSE) begin
      // pop down to the matching open, which is discarded
      while (op_depth > 0 && !matched) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top == CODE_OPEN) matched = 1'b1;
        else step_results.push_back('{op_symbol(top), ERR_NONE, 1'b0});
      end
      if (!matched) step_results.push_back('{8'h00, ERR_CLOSE, 1'b0});
    end else if (code != CODE_NONE) begin
      // pop equal or higher rank, stop at an open or a lower rank
      while (op_depth > 0 && op_stack[op_depth - 1] != CODE_OPEN &&
             !(op_stack[op_depth - 1] < CODE_MUL && code >= CODE_MUL)) begin
        op_depth--;
        step_results.push_back('{op_symbol(op_stack[op_depth]), ERR_NONE, 1'b0});
      end
      stack_push(code);
    end else begin
      step_results.push_back('{8'h00, ERR_ILLEGAL, 1'b0});
    end

    if (eoe) begin
      while (op_depth > 0) begin
        op_depth--;
        if (op_stack[op_depth] == CODE_OPEN)
          step_results.push_back('{8'h00, ERR_OPEN, 1'b0});
        else
          step_results.push_back('{op_symbol(op_stack[op_depth]), ERR_NONE, 1'b0});
      end
    end

    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // offer one character; bursts of back-to-back offers, most of them preceded by an idle gap
  task automatic send_char(input logic [7:0] sym, input logic eoe, input logic typed,
                           input logic [7:0] t_sym, input err_code_t t_err);
    logic hit;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_end_of_expression <= eoe;
    // handshake is judged at the falling clock edge ahead of the sampling edge, where both sides are settled
    do begin
      @(negedge clk);
      hit = in_ready;
      if (hit) begin
        shunt_step(sym, eoe);
        if (typed) pending_postfix.push_back('{t_sym, t_err, 1'b1});
        else foreach (step_results[i]) pending_postfix.push_back(step_results[i]);
      end
      @(posedge clk);
    end while (!hit);
    chars_sent++;
  endtask

  // random expression: mostly well formed, sometimes deep enough to overflow,
  // sometimes with opens left over, a corrupted character or a stray close
  task automatic send_expression();
    logic [7:0] chars [$];
    logic [7:0] opers [4];
    int operands;
    int depth;
    int opens;
    int closes;
    logic deep;
    opers = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};
    chars = {};
    depth = 0;
    operands = $urandom_range(1, 6);
    deep = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < operands; k++) begin
      if (deep && k == 0) opens = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
      else opens = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (opens) begin
        chars.push_back(CHAR_OPEN);
        depth++;
      end
      chars.push_back(CHAR_LOW_A + 8'($urandom_range(0, 25)));
      closes = (depth > 0 && $urandom_range(0, 2) == 0) ? $urandom_range(1, depth) : 0;
      repeat (closes) begin
        chars.push_back(CHAR_CLOSE);
        depth--;
      end
      if (k != operands - 1) chars.push_back(opers[$urandom_range(0, 3)]);
    end
    // most expressions close every open, the rest leave some for the flush
    if ($urandom_range(0, 4) != 0) begin
      repeat (depth) chars.push_back(CHAR_CLOSE);
    end
    if ($urandom_range(0, 5) == 0)
      chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0)
      chars.insert($urandom_range(0, chars.size()), CHAR_CLOSE);
    foreach (chars[i])
      send_char(chars[i], i == chars.size() - 1, 1'b0, 8'h00, ERR_NONE);
  endtask

  // receiver: switches at random among stall patterns
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(16, 96);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:      out_ready <= (ready_tick % 3 == 0);
    endcase
  end

  // result checker and watchdog, both sampled mid-cycle ahead of the next edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_postfix.size() == 0) begin
          $error("unexpected transaction: out_symbol %h out_error_code %0d out_last_of_run %b",
                 out_symbol, out_error_code, out_last_of_run);
          fail_count++;
        end else begin
          want = pending_postfix.pop_front();
          if (out_symbol !== want.sym) begin
            $error("out_symbol: expected %h, actual %h", want.sym, out_symbol);
            fail_count++;
          end
          if (out_error_code !== want.err) begin
            $error("out_error_code: expected %0d, actual %0d", want.err, out_error_code);
            fail_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %b, actual %b", want.last, out_last_of_run);
            fail_count++;
          end
        end
      end
      // any transaction on either channel shows forward progress
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    // synchronous reset held low at the start, then released
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED[r]) begin
      repeat (DIRECTED[r].reps)
        send_char(DIRECTED[r].sym, DIRECTED[r].eoe, DIRECTED[r].typed,
                  DIRECTED[r].t_sym, DIRECTED[r].t_err);
    end

    // random part: expressions with random content, plus lone random bytes
    chars_sent = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0)
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 8'h00, ERR_NONE);
      else
        send_expression();
    end
    in_valid <= 1'b0;

    // drain outstanding results, then watch for anything extra
    while (pending_postfix.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
